/* design/assert_macros.svh */
// Assertion helpers, included by quaternion_to_euler_angles.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* design/qte_pkg.sv */
package qte_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    // Square root steps: one result bit per step for a 61-bit radicand.
    localparam int ISQRT_STEPS = 31;
    localparam int SUM_W = 35;
    localparam int VEC_W = 36;
    localparam int ROOT_W = 62;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic               pitch_clamped;
    } t_euler;

    // atan(2^-i) with 2^31 standing for pi.
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            5'd31: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

/* design/qte_quat_if.sv */
interface qte_quat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;

    modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

/* design/qte_euler_if.sv */
interface qte_euler_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;

    modport source(output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                   input ready);
    modport sink(input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                 output ready);
endinterface

/* design/qte_cordic.sv */
// Vectoring CORDIC: one pre-rotation register, then one register per micro-rotation.
module qte_cordic #(
    parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [qte_pkg::VEC_W-1:0] i_y,
    input  logic signed [qte_pkg::VEC_W-1:0] i_x,
    output logic signed [15:0]              o_angle
);
    logic signed [qte_pkg::VEC_W-1:0] r_x [0:STAGES];
    logic signed [qte_pkg::VEC_W-1:0] r_y [0:STAGES];
    logic [31:0]                      r_z [0:STAGES];
    logic                             r_zero [0:STAGES];
    logic [31:0]                      rounded;

    // Vectors in the left half plane are turned by pi first.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= 32'h80000000;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [qte_pkg::VEC_W-1:0] dx;
        logic signed [qte_pkg::VEC_W-1:0] dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + qte_pkg::atan_entry(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - qte_pkg::atan_entry(5'(i));
                end
            end
        end
    end

    assign rounded = r_z[STAGES] + 32'h00008000;
    assign o_angle = r_zero[STAGES] ? '0 : $signed(rounded[31:16]);
endmodule

/* design/quaternion_to_euler_angles.sv */
// Converts a unit quaternion (w, x, y, z), each signed Q1.15, into Z-Y-X roll, pitch
// and yaw as signed 16-bit binary angles where 32768 stands for pi. Roll and yaw are
// atan2 of the usual Q2.30 sum-of-products terms; pitch is asin(2(wy - zx)), found as
// atan2(s, sqrt(1 - s^2)). When |2(wy - zx)| reaches one, pitch is clamped to plus or
// minus 16384 and pitch_clamped is set. The quaternion is used as given, with no
// normalization. One item is accepted every clock cycle while input ready is high. The
// input register is followed by the product and sum registers, the squared-sine and
// clamp register, the radicand register, the square root stages with one result bit
// each, the pre-rotation and micro-rotation registers of the three parallel CORDIC
// pipelines, the result assembly register and the output register. A skid register
// behind the output register takes the item that arrives while the consumer stalls;
// input ready is low only while that skid register holds an item.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qte_quat_if.sink    i_quat,
    qte_euler_if.source o_euler
);
    `include "assert_macros.svh"

    localparam int SW  = qte_pkg::SUM_W;
    localparam int RW  = qte_pkg::ROOT_W;
    localparam int VW  = qte_pkg::VEC_W;
    localparam int ISQ = qte_pkg::ISQRT_STEPS;
    localparam int NV  = 5 + ISQ + CORDIC_STAGES + 2;
    localparam logic signed [SW-1:0] ONE_Q30 = SW'(64'sd1 <<< 30);

    logic            en;
    logic            push;
    logic [NV-1:0]   r_vld;

    // Stage A: input registers.
    logic signed [15:0] r_a_w, r_a_x, r_a_y, r_a_z;
    // Stage B: products in Q2.30.
    logic signed [31:0] r_b_wx, r_b_yz, r_b_xx, r_b_yy, r_b_wy, r_b_zx;
    logic signed [31:0] r_b_wz, r_b_xy, r_b_zz;
    // Stage C: the five terms.
    logic signed [SW-1:0] r_c_sr, r_c_cr, r_c_sp, r_c_sy, r_c_cy;
    // Stage D: squared pitch sine and clamp decision.
    logic signed [SW-1:0] r_d_sr, r_d_cr, r_d_sp, r_d_sy, r_d_cy;
    logic [59:0]          r_d_sq;
    logic [1:0]           r_d_cl;
    logic [29:0]          sp_mag;

    // Square root pipeline; entry 0 is stage E.
    logic [RW-1:0]        r_q_n   [0:ISQ];
    logic [RW-1:0]        r_q_res [0:ISQ];
    logic signed [SW-1:0] r_q_sr  [0:ISQ];
    logic signed [SW-1:0] r_q_cr  [0:ISQ];
    logic signed [SW-1:0] r_q_sp  [0:ISQ];
    logic signed [SW-1:0] r_q_sy  [0:ISQ];
    logic signed [SW-1:0] r_q_cy  [0:ISQ];
    logic [1:0]           r_q_cl  [0:ISQ];

    // Clamp bits (bit 1 positive, bit 0 negative) ride alongside the CORDICs.
    logic [1:0]           r_cl_d  [0:CORDIC_STAGES];
    logic signed [15:0]   roll_a, pitch_a, yaw_a;

    qte_pkg::t_euler r_f, r_o, r_s;
    logic            r_o_v, r_s_v;

    assign en           = !r_s_v;
    assign push         = en && r_vld[NV-1];
    assign i_quat.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_quat.valid};
        end
    end

    assign sp_mag = r_c_sp[SW-1] ? 30'(-r_c_sp) : r_c_sp[29:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_w  <= i_quat.quat_w;
            r_a_x  <= i_quat.quat_x;
            r_a_y  <= i_quat.quat_y;
            r_a_z  <= i_quat.quat_z;

            r_b_wx <= r_a_w * r_a_x;
            r_b_yz <= r_a_y * r_a_z;
            r_b_xx <= r_a_x * r_a_x;
            r_b_yy <= r_a_y * r_a_y;
            r_b_wy <= r_a_w * r_a_y;
            r_b_zx <= r_a_z * r_a_x;
            r_b_wz <= r_a_w * r_a_z;
            r_b_xy <= r_a_x * r_a_y;
            r_b_zz <= r_a_z * r_a_z;

            r_c_sr <= (SW'(r_b_wx) + SW'(r_b_yz)) <<< 1;
            r_c_cr <= ONE_Q30 - ((SW'(r_b_xx) + SW'(r_b_yy)) <<< 1);
            r_c_sp <= (SW'(r_b_wy) - SW'(r_b_zx)) <<< 1;
            r_c_sy <= (SW'(r_b_wz) + SW'(r_b_xy)) <<< 1;
            r_c_cy <= ONE_Q30 - ((SW'(r_b_yy) + SW'(r_b_zz)) <<< 1);

            r_d_sr <= r_c_sr;
            r_d_cr <= r_c_cr;
            r_d_sp <= r_c_sp;
            r_d_sy <= r_c_sy;
            r_d_cy <= r_c_cy;
            r_d_sq <= sp_mag * sp_mag;
            r_d_cl <= {r_c_sp >= ONE_Q30, r_c_sp <= -ONE_Q30};

            // The radicand 2^60 - s^2 only matters when the pitch is not clamped.
            r_q_n[0]   <= (RW'(1) << 60) - RW'(r_d_sq);
            r_q_res[0] <= '0;
            r_q_sr[0]  <= r_d_sr;
            r_q_cr[0]  <= r_d_cr;
            r_q_sp[0]  <= r_d_sp;
            r_q_sy[0]  <= r_d_sy;
            r_q_cy[0]  <= r_d_cy;
            r_q_cl[0]  <= r_d_cl;
        end
    end

    // Digit-by-digit integer square root, one result bit per stage.
    for (genvar k = 0; k < ISQ; k++) begin : g_isqrt
        localparam logic [RW-1:0] BIT = RW'(1) << (60 - 2 * k);
        logic [RW-1:0] trial;
        assign trial = r_q_res[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_q_n[k] >= trial) begin
                    r_q_n[k+1]   <= r_q_n[k] - trial;
                    r_q_res[k+1] <= (r_q_res[k] >> 1) + BIT;
                end else begin
                    r_q_n[k+1]   <= r_q_n[k];
                    r_q_res[k+1] <= r_q_res[k] >> 1;
                end
                r_q_sr[k+1] <= r_q_sr[k];
                r_q_cr[k+1] <= r_q_cr[k];
                r_q_sp[k+1] <= r_q_sp[k];
                r_q_sy[k+1] <= r_q_sy[k];
                r_q_cy[k+1] <= r_q_cy[k];
                r_q_cl[k+1] <= r_q_cl[k];
            end
        end
    end

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_y    (VW'(r_q_sr[ISQ])),
        .i_x    (VW'(r_q_cr[ISQ])),
        .o_angle(roll_a)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_y    (VW'(r_q_sp[ISQ])),
        .i_x    (VW'($signed({1'b0, r_q_res[ISQ][30:0]}))),
        .o_angle(pitch_a)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_y    (VW'(r_q_sy[ISQ])),
        .i_x    (VW'(r_q_cy[ISQ])),
        .o_angle(yaw_a)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cl_d[0] <= r_q_cl[ISQ];
        end
    end

    for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cl
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cl_d[j+1] <= r_cl_d[j];
            end
        end
    end

    // Result assembly: gimbal lock overrides the CORDIC pitch.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f.roll_angle    <= roll_a;
            r_f.yaw_angle     <= yaw_a;
            r_f.pitch_clamped <= |r_cl_d[CORDIC_STAGES];
            priority if (r_cl_d[CORDIC_STAGES][1]) begin
                r_f.pitch_angle <= 16'sd16384;
            end else if (r_cl_d[CORDIC_STAGES][0]) begin
                r_f.pitch_angle <= -16'sd16384;
            end else begin
                r_f.pitch_angle <= pitch_a;
            end
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
            r_s_v <= 1'b0;
        end else if (!r_o_v || o_euler.ready) begin
            r_o_v <= r_s_v || push;
            r_s_v <= 1'b0;
        end else if (push) begin
            r_s_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_v || o_euler.ready) begin
            r_o <= r_s_v ? r_s : r_f;
        end else if (push) begin
            r_s <= r_f;
        end
    end

    assign o_euler.valid         = r_o_v;
    assign o_euler.roll_angle    = r_o.roll_angle;
    assign o_euler.pitch_angle   = r_o.pitch_angle;
    assign o_euler.yaw_angle     = r_o.yaw_angle;
    assign o_euler.pitch_clamped = r_o.pitch_clamped;

    `ASSERT_CLK(a_skid_behind_out, i_clk, i_rst_n, r_s_v |-> r_o_v,
        "skid full with empty output")
    `ASSERT_CLK(a_stall_holds, i_clk, i_rst_n, r_s_v |=> $stable(r_vld),
        "pipeline moved while stalled")
    `ASSERT_CLK(a_clamp_value, i_clk, i_rst_n, (r_o_v && r_o.pitch_clamped) |->
        (r_o.pitch_angle == 16'sd16384 || r_o.pitch_angle == -16'sd16384),
        "clamped pitch not at a pole")
    `ASSERT_NEVER(a_pitch_range, i_clk, i_rst_n,
        r_o_v && (r_o.pitch_angle > 16'sd16384 || r_o.pitch_angle < -16'sd16384),
        "pitch out of range")
endmodule

/* dv/qte_tb_ifs.sv */
`timescale 1ns / 100ps

// The testbench uses the design's own channel interfaces, qte_quat_if and qte_euler_if.
// This file only holds the item type that the checker keeps in its queue.
package qte_tb_pkg;
    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } t_angles;
endpackage

/* dv/qte_checker.sv */
`timescale 1ns / 100ps

module qte_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qte_quat_if         i_quat,
    qte_euler_if        i_euler,
    output int          o_errors,
    output int          o_pending
);
    import qte_tb_pkg::*;

    localparam int STAGES = 16;
    localparam longint ONE_Q30 = 64'sd1 << 30;

    t_angles angles_due[$];
    int      errors;

    assign o_errors  = errors;
    assign o_pending = angles_due.size();

    function automatic logic [31:0] arctan_step(input int i);
        logic [31:0] t [32] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
            32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
            32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
            32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
        return t[i];
    endfunction

    // Vectoring CORDIC; >>> on a signed longint is a floor shift.
    function automatic logic [31:0] vector_angle(input longint vy, input longint vx);
        logic [31:0] acc;
        longint      ddx;
        longint      ddy;
        acc = 32'h0;
        if (vx == 0 && vy == 0) return 32'h0;
        if (vx < 0) begin
            vx  = -vx;
            vy  = -vy;
            acc = 32'h80000000;
        end
        for (int i = 0; i < STAGES; i++) begin
            ddx = vy >>> i;
            ddy = vx >>> i;
            if (vy >= 0) begin
                vx  = vx + ddx;
                vy  = vy - ddy;
                acc = acc + arctan_step(i);
            end else begin
                vx  = vx - ddx;
                vy  = vy + ddy;
                acc = acc - arctan_step(i);
            end
        end
        return acc;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] to_bam16(input logic [31:0] a);
        logic [31:0] s;
        s = a + 32'h8000;
        return s[31:16];
    endfunction

    function automatic t_angles euler_of(input longint w, input longint x,
                                         input longint y, input longint z);
        t_angles r;
        longint  sr;
        longint  cr;
        longint  sp;
        longint  sy;
        longint  cy;
        logic [63:0] c;
        sr = 2 * (w * x + y * z);
        cr = ONE_Q30 - 2 * (x * x + y * y);
        sp = 2 * (w * y - z * x);
        sy = 2 * (w * z + x * y);
        cy = ONE_Q30 - 2 * (y * y + z * z);
        r.roll = to_bam16(vector_angle(sr, cr));
        r.yaw  = to_bam16(vector_angle(sy, cy));
        if (sp >= ONE_Q30) begin
            r.pitch   = 16'sd16384;
            r.clamped = 1'b1;
        end else if (sp <= -ONE_Q30) begin
            r.pitch   = -16'sd16384;
            r.clamped = 1'b1;
        end else begin
            c         = int_sqrt((64'd1 << 60) - 64'(sp * sp));
            r.pitch   = to_bam16(vector_angle(sp, longint'(c)));
            r.clamped = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge i_clk) begin
        t_angles e;
        if (i_rst_n && i_quat.valid && i_quat.ready)
            angles_due.push_back(euler_of(i_quat.quat_w, i_quat.quat_x,
                                          i_quat.quat_y, i_quat.quat_z));
        if (i_rst_n && i_euler.valid && i_euler.ready) begin
            if (angles_due.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                e = angles_due.pop_front();
                if (i_euler.roll_angle !== e.roll)
                    report_mismatch("roll", i_euler.roll_angle, e.roll);
                if (i_euler.pitch_angle !== e.pitch)
                    report_mismatch("pitch", i_euler.pitch_angle, e.pitch);
                if (i_euler.yaw_angle !== e.yaw)
                    report_mismatch("yaw", i_euler.yaw_angle, e.yaw);
                if (i_euler.pitch_clamped !== e.clamped)
                    report_mismatch("clamp", i_euler.pitch_clamped, e.clamped);
            end
        end
    end
endmodule

/* dv/tb_quaternion_to_euler_angles.sv */
`timescale 1ns / 100ps

module tb_quaternion_to_euler_angles;

    // The drain wait covers the latency of the block generously.
    localparam int DRAIN_CYCLES = 200;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   sink_mode;   // 0 normal random stalls, 1 long hold-off

    qte_quat_if  quat_ch();
    qte_euler_if euler_ch();

    quaternion_to_euler_angles i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (quat_ch.sink),
        .o_euler (euler_ch.source)
    );

    qte_checker i_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_quat    (quat_ch),
        .i_euler   (euler_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: far above the slowest correct run of about 1000 items with random gaps.
    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    // Drives one quaternion and holds it until the block takes it. The valid is left
    // high when the next item follows with no gap, so it is never dropped and raised
    // within one step.
    task automatic send_quat(input logic [15:0] w, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z,
                             input int gap);
        repeat (gap) begin
            quat_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        quat_ch.valid  <= 1'b1;
        quat_ch.quat_w <= w;
        quat_ch.quat_x <= x;
        quat_ch.quat_y <= y;
        quat_ch.quat_z <= z;
        @(posedge i_clk);
        while (!quat_ch.ready) @(posedge i_clk);
    endtask

    // Picks a quaternion, some in the gimbal lock shape, most scaled toward unit norm.
    task automatic send_unit_quat(input int gap);
        int w;
        int x;
        int y;
        int z;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            // Pitch near +/- 90 degrees when w is large: y = +/-w, z = +/-x, x small.
            w = $urandom_range(0, 23170) + $urandom_range(0, 200) - 100;
            x = $urandom_range(0, 300) - 150;
            y = ($urandom_range(0, 1) ? w : -w) + $urandom_range(0, 8) - 4;
            z = ($urandom_range(0, 1) ? x : -x);
            w = $urandom_range(0, 1) ? -w : w;
        end else begin
            w = $urandom_range(0, 65535) - 32768;
            x = $urandom_range(0, 65535) - 32768;
            y = $urandom_range(0, 65535) - 32768;
            z = $urandom_range(0, 65535) - 32768;
            if (sel < 8) begin
                // Scale toward unit norm so results cover the useful range.
                real n;
                n = $sqrt(real'(w) * w + real'(x) * x + real'(y) * y + real'(z) * z);
                if (n > 1.0) begin
                    w = int'(w * 32767.0 / n);
                    x = int'(x * 32767.0 / n);
                    y = int'(y * 32767.0 / n);
                    z = int'(z * 32767.0 / n);
                end
            end
        end
        send_quat(w[15:0], x[15:0], y[15:0], z[15:0], gap);
    endtask

    // Result side: random stalls per item, or one long hold-off on request.
    initial begin
        int stall;
        euler_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (sink_mode == 1) begin
                euler_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                sink_mode = 0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                euler_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            euler_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!euler_ch.valid) @(posedge i_clk);
        end
    end

    initial begin
        int gap;
        int wait_cnt;
        sink_mode      = 0;
        i_rst_n        <= 1'b0;
        quat_ch.valid  <= 1'b0;
        quat_ch.quat_w <= '0;
        quat_ch.quat_x <= '0;
        quat_ch.quat_y <= '0;
        quat_ch.quat_z <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items: identity, zero vector, extreme components, both gimbal
        // locks, negative abscissa giving an angle of pi, and non-unit inputs.
        send_quat(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 0);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1);
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
        send_quat(16'h5A82, 16'h0000, 16'h5A82, 16'h0000, 2);
        send_quat(16'h5A82, 16'h0000, 16'hA57E, 16'h0000, 0);
        send_quat(16'h5A82, 16'h1000, 16'h5A82, 16'hF000, 0);
        send_quat(16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 3);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 0);
        send_quat(16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 0);
        send_quat(16'h0000, 16'h8000, 16'h0000, 16'h0000, 0);
        send_quat(16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 1);
        send_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 0);
        send_quat(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 0);
        send_quat(16'h4000, 16'h4000, 16'h4000, 16'h4000, 0);
        send_quat(16'h4000, 16'hC000, 16'h4000, 16'hC000, 0);
        send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 0);

        for (int n = 0; n < 1000; n++) begin
            // A long receiver hold-off while items keep coming fills the pipeline.
            if (n == 300) sink_mode = 1;
            // Once, the sender pauses until every expected result has arrived.
            if (n == 600) begin
                quat_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            if (n >= 300 && n < 420) gap = 0;
            else if (n % 200 < 40) gap = 0;
            else gap = $urandom_range(0, 16);
            send_unit_quat(gap);
        end
        quat_ch.valid <= 1'b0;

        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* quaternion_to_euler_angles.f */
+incdir+design
design/qte_pkg.sv
design/qte_quat_if.sv
design/qte_euler_if.sv
design/qte_cordic.sv
design/quaternion_to_euler_angles.sv
dv/qte_tb_ifs.sv
dv/qte_checker.sv
dv/tb_quaternion_to_euler_angles.sv
